// ----- sv/lru_key_value_cache_defines.svh -----
// Assertion macros for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that holds at every clock edge out of reset.
`define LKV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define LKV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LKV_ASSERT(label, clk, rst_n, prop, msg)
`define LKV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/lkv_pkg.sv -----
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int CAP_WIDTH = 5;
	localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_ACT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic latch_in;
		logic lookup;
		logic promote;
		logic insert;
		logic evict;
		logic wr_data;
		logic rd_data;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_put;
		logic hit;
		logic full;
	} stat_t;

endpackage

// ----- sv/lkv_in_if.sv -----
`timescale 1ns / 1ps

interface lkv_in_if #(
	parameter int KEY_WIDTH  = 32,
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic signed [KEY_WIDTH-1:0]  key;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output operation, output key, output value, input ready);
	modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

// ----- sv/lkv_out_if.sv -----
`timescale 1ns / 1ps

interface lkv_out_if #(
	parameter int KEY_WIDTH  = 32,
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic signed [DATA_WIDTH-1:0] read_value;
	logic                         evicted;
	logic signed [KEY_WIDTH-1:0]  evicted_key;

	modport source (output valid, output hit, output read_value, output evicted,
		output evicted_key, input ready);
	modport sink   (input valid, input hit, input read_value, input evicted,
		input evicted_key, output ready);
endinterface

// ----- sv/lkv_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM, read-first, registered read.
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- sv/lkv_ctrl.sv -----
`timescale 1ns / 1ps

module lkv_ctrl import lkv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
				if (in_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = ST_ACT;
			end
			ST_ACT: begin
				cmd.promote = stat.hit;
				cmd.insert  = stat.is_put && !stat.hit;
				cmd.evict   = stat.is_put && !stat.hit && stat.full;
				cmd.wr_data = stat.is_put;
				cmd.rd_data = !stat.is_put && stat.hit;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

// ----- sv/lkv_dp.sv -----
`timescale 1ns / 1ps
`include "lru_key_value_cache_defines.svh"

module lkv_dp import lkv_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int KEY_WIDTH  = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CAP_WIDTH-1:0]         cfg_wdata,
	input  logic                         in_operation,
	input  logic [KEY_WIDTH-1:0]         in_key,
	input  logic [DATA_WIDTH-1:0]        in_value,
	input  cmd_t                         cmd,
	output stat_t                        stat,
	output logic                         out_hit,
	output logic [DATA_WIDTH-1:0]        out_read_value,
	output logic                         out_evicted,
	output logic [KEY_WIDTH-1:0]         out_evicted_key
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW = IW;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int XW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

	logic [CAP_WIDTH-1:0]  cap_q;
	logic                  op_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [DATA_WIDTH-1:0] value_q;

	logic [ENTRIES-1:0]    valid_q;
	logic [KEY_WIDTH-1:0]  ckey_q [ENTRIES];
	logic [RW-1:0]         rank_q [ENTRIES];
	logic [CW-1:0]         count_q;

	logic [ENTRIES-1:0]    match_q;
	logic [ENTRIES-1:0]    lru_q;
	logic [IW-1:0]         found_idx_q;
	logic [IW-1:0]         lru_idx_q;
	logic [RW-1:0]         found_rank_q;
	logic                  full_q;

	logic                  out_hit_q;
	logic [DATA_WIDTH-1:0] out_rd_q;
	logic                  out_ev_q;
	logic [KEY_WIDTH-1:0]  out_evk_q;

	logic [ENTRIES-1:0]    match_d;
	logic [ENTRIES-1:0]    lru_d;
	logic [IW-1:0]         found_idx_d;
	logic [IW-1:0]         lru_idx_d;
	logic [RW-1:0]         found_rank_d;
	logic [RW-1:0]         cnt_m1;
	logic                  full_d;
	logic [XW-1:0]         cap_x;
	logic [XW-1:0]         cnt_x;

	logic [ENTRIES-1:0]    kept;
	logic [ENTRIES-1:0]    slot_oh;
	logic [IW-1:0]         slot_idx;

	logic                  is_hit;
	logic                  ev_now;
	logic [DATA_WIDTH-1:0] data_rdata;
	logic [KEY_WIDTH-1:0]  key_rdata;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q    <= in_operation;
			key_q   <= in_key;
			value_q <= in_value;
		end
	end

	// Lookup: parallel key compare, LRU is the valid entry holding rank count-1
	always_comb begin
		cnt_m1       = RW'(count_q - CW'(1));
		found_idx_d  = '0;
		lru_idx_d    = '0;
		found_rank_d = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_d[i] = valid_q[i] && (ckey_q[i] == key_q);
			lru_d[i]   = valid_q[i] && (rank_q[i] == cnt_m1);
			if (match_d[i]) begin
				found_idx_d  = found_idx_d | IW'(i);
				found_rank_d = found_rank_d | rank_q[i];
			end
			if (lru_d[i]) begin
				lru_idx_d = lru_idx_d | IW'(i);
			end
		end
		cap_x  = XW'(cap_q);
		cnt_x  = XW'(count_q);
		full_d = (cnt_x >= XW'(ENTRIES)) ||
			((cap_x == '0) ? (cnt_x != '0) : (cnt_x >= cap_x));
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			match_q      <= match_d;
			lru_q        <= lru_d;
			found_idx_q  <= found_idx_d;
			lru_idx_q    <= lru_idx_d;
			found_rank_q <= found_rank_d;
			full_q       <= full_d;
		end
	end

	// Free slot: lowest entry not kept after a possible eviction
	always_comb begin
		kept     = valid_q & ~(cmd.evict ? lru_q : '0);
		slot_oh  = ~kept & (kept + ENTRIES'(1));
		slot_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_oh[i]) begin
				slot_idx = slot_idx | IW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.insert) begin
			valid_q <= kept | slot_oh;
			if (!cmd.evict) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.promote) begin
				if (match_q[i]) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (rank_q[i] < found_rank_q)) begin
					rank_q[i] <= rank_q[i] + RW'(1);
				end
			end else if (cmd.insert) begin
				if (slot_oh[i]) begin
					rank_q[i] <= '0;
					ckey_q[i] <= key_q;
				end else if (kept[i]) begin
					rank_q[i] <= rank_q[i] + RW'(1);
				end
			end
		end
	end

	lkv_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(ENTRIES)
	) u_data_ram (
		.clk  (clk),
		.we   (cmd.wr_data),
		.waddr(cmd.promote ? found_idx_q : slot_idx),
		.wdata(value_q),
		.re   (cmd.rd_data),
		.raddr(found_idx_q),
		.rdata(data_rdata)
	);

	lkv_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (cmd.insert),
		.waddr(slot_idx),
		.wdata(key_q),
		.re   (cmd.evict),
		.raddr(lru_idx_q),
		.rdata(key_rdata)
	);

	assign is_hit      = |match_q;
	assign ev_now      = (op_q == OP_PUT) && !is_hit && full_q;
	assign stat.is_put = (op_q == OP_PUT);
	assign stat.hit    = is_hit;
	assign stat.full   = full_q;

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hit_q <= is_hit;
			out_ev_q  <= ev_now;
			out_evk_q <= ev_now ? key_rdata : '0;
			if (op_q == OP_PUT) begin
				out_rd_q <= '0;
			end else if (is_hit) begin
				out_rd_q <= data_rdata;
			end else begin
				out_rd_q <= '1;
			end
		end
	end

	assign out_hit         = out_hit_q;
	assign out_read_value  = out_rd_q;
	assign out_evicted     = out_ev_q;
	assign out_evicted_key = out_evk_q;

	`LKV_ASSERT(a_count_matches_valid, clk, arst_n, $countones(valid_q) == int'(count_q), "occupancy count out of step with valid bits")
	`LKV_ASSERT_IMPL(a_single_match, clk, arst_n, cmd.promote, $onehot(match_q), "key present in more than one entry")
	`LKV_ASSERT_IMPL(a_lru_unique, clk, arst_n, cmd.evict, $onehot(lru_q), "no unique least recent entry to evict")
	`LKV_ASSERT_NEXT(a_insert_fills, clk, arst_n, cmd.insert, count_q != '0, "insert left the store empty")
endmodule

// ----- sv/lru_key_value_cache.sv -----
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement. Each request item
// is a get or a put; each produces exactly one response item. After a request is accepted,
// the control sequencer steps through the parallel key compare, the entry/rank update with
// RAM access and the response load, and a new request is accepted only once it is back in
// idle, after the load of the previous response. The next request is taken while the
// previous response waits on rsp; a response still held there delays the load of the next
// one until it is taken. The capacity register (reset 16) limits occupancy: 0 acts as 1,
// values above ENTRIES act as ENTRIES. Write it only while the cache is idle.
module lru_key_value_cache import lkv_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int KEY_WIDTH  = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CAP_WIDTH-1:0] cfg_wdata,
	lkv_in_if.sink               req,
	lkv_out_if.source            rsp
);
	cmd_t  cmd;
	stat_t stat;

	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lkv_dp #(
		.ENTRIES   (ENTRIES),
		.KEY_WIDTH (KEY_WIDTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_operation   (req.operation),
		.in_key         (req.key),
		.in_value       (req.value),
		.cmd            (cmd),
		.stat           (stat),
		.out_hit        (rsp.hit),
		.out_read_value (rsp.read_value),
		.out_evicted    (rsp.evicted),
		.out_evicted_key(rsp.evicted_key)
	);
endmodule
